/* sv/sust_pkg.sv */
// ----------------------------------------------------------------------------
// sust_pkg
// Shared types and constants for the sorted unique set table.
// ----------------------------------------------------------------------------
package sust_pkg;

    localparam int SUST_CAPACITY = 32;
    localparam int SUST_DATA_W   = 32;
    localparam int SUST_COUNT_W  = 6;

    typedef enum logic [2:0] {
        OUT_INSERTED  = 3'd0,
        OUT_DUPLICATE = 3'd1,
        OUT_FULL      = 3'd2,
        OUT_EMPTY     = 3'd3,
        OUT_FIRST     = 3'd4,
        OUT_LAST      = 3'd5,
        OUT_MIDDLE    = 3'd6,
        OUT_NOT_FOUND = 3'd7
    } outcome_t;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOCATE = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic shift;
        logic place;
        logic mid;
    } sust_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_stop;
        logic do_shift;
        logic shift_end;
    } sust_status_t;

endpackage

/* sv/sorted_unique_set_table_core.sv */
// ----------------------------------------------------------------------------
// Locate, duplicate and full go from the scan straight to the middle read; an
// accepted insert first shifts the larger entries and places the key. The scan
// reads one entry per cycle through the single read port; the shift of larger
// entries then moves one a cycle. Throughput: one item at a time; start is
// taken again the cycle after done. The receiver cannot stall.
// Reset (rst_n, asynchronous) empties the table; entry storage is not cleared.
// ----------------------------------------------------------------------------
// sorted_unique_set_table_core
// Ascending table of distinct signed values with insert and locate actions.
// ----------------------------------------------------------------------------
module sorted_unique_set_table_core
    import sust_pkg::*;
#(
    parameter int CAPACITY = SUST_CAPACITY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          action,
    input  logic signed [SUST_DATA_W-1:0] value,
    output logic                          done,
    output logic [2:0]                    outcome,
    output logic [SUST_COUNT_W-1:0]       entry_count,
    output logic signed [SUST_DATA_W-1:0] middle_value,
    output logic                          middle_valid
);

    sust_cmd_t    cmd;
    sust_status_t status;

    sust_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .status (status)
    );

    sust_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .action       (action),
        .value        (value),
        .outcome      (outcome),
        .entry_count  (entry_count),
        .middle_value (middle_value),
        .middle_valid (middle_valid)
    );

endmodule

/* sv/sust_ram.sv */
// ----------------------------------------------------------------------------
// sust_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sust_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/sust_ctrl.sv */
// ----------------------------------------------------------------------------
// sust_ctrl
// Sequencer for scan, shift, place, middle read and result strobe.
// ----------------------------------------------------------------------------
module sust_ctrl
    import sust_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    output logic         done,
    output sust_cmd_t    cmd,
    input  sust_status_t status
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_SHIFT = 6'b000100,
        S_PLACE = 6'b001000,
        S_MID   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_stop)
                begin
                    state_next = status.do_shift ? S_SHIFT : S_MID;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (status.shift_end)
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_MID;
            end
            S_MID:
            begin
                cmd.mid    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

/* sv/sust_datapath.sv */
// ----------------------------------------------------------------------------
// sust_datapath
// Entry store, scan/shift pointers, comparator and result registers.
// ----------------------------------------------------------------------------
module sust_datapath
    import sust_pkg::*;
#(
    parameter int CAPACITY = SUST_CAPACITY
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sust_cmd_t                      cmd,
    output sust_status_t                   status,
    input  logic                           action,
    input  logic signed [SUST_DATA_W-1:0]  value,
    output logic [2:0]                     outcome,
    output logic [SUST_COUNT_W-1:0]        entry_count,
    output logic signed [SUST_DATA_W-1:0]  middle_value,
    output logic                           middle_valid
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic                   action_reg;
    logic [SUST_DATA_W-1:0] key_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          ptr_reg;
    logic [CW-1:0]          ptr_next;
    logic                   pend_reg;
    logic                   pend_next;
    logic [AW-1:0]          pend_idx_reg;
    logic [AW-1:0]          pend_idx_next;
    logic [CW-1:0]          pos_reg;
    outcome_t               outcome_reg;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [SUST_DATA_W-1:0] ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [SUST_DATA_W-1:0] ram_rdata;

    logic                   scan_issue;
    logic                   shift_issue;
    logic                   hit_now;
    logic                   stop_now;
    logic [CW-1:0]          pos_now;
    logic [CW-1:0]          ptr_dec;
    logic                   full;
    outcome_t               outcome_now;

    assign ptr_dec     = ptr_reg - 1'b1;
    assign full        = (count_reg >= CAP_C);
    assign scan_issue  = cmd.scan && (ptr_reg < count_reg);
    assign shift_issue = cmd.shift && (ptr_reg > pos_reg);

    // scan stops at the first entry not below the key
    always_comb
    begin
        hit_now  = 1'b0;
        stop_now = 1'b0;
        pos_now  = ptr_reg;
        if (pend_reg)
        begin
            pos_now = CW'(pend_idx_reg);
            if (ram_rdata == key_reg)
            begin
                hit_now  = 1'b1;
                stop_now = 1'b1;
            end
            else if ($signed(key_reg) < $signed(ram_rdata))
            begin
                stop_now = 1'b1;
            end
        end
        else if (ptr_reg == count_reg)
        begin
            stop_now = 1'b1;
        end
    end

    always_comb
    begin
        if (action_reg == ACT_INSERT)
        begin
            if (hit_now)
            begin
                outcome_now = OUT_DUPLICATE;
            end
            else if (full)
            begin
                outcome_now = OUT_FULL;
            end
            else
            begin
                outcome_now = OUT_INSERTED;
            end
        end
        else
        begin
            if (count_reg == '0)
            begin
                outcome_now = OUT_EMPTY;
            end
            else if (!hit_now)
            begin
                outcome_now = OUT_NOT_FOUND;
            end
            else if (pos_now == '0)
            begin
                outcome_now = OUT_FIRST;
            end
            else if (pos_now == count_reg - 1'b1)
            begin
                outcome_now = OUT_LAST;
            end
            else
            begin
                outcome_now = OUT_MIDDLE;
            end
        end
    end

    assign status.scan_stop = cmd.scan && stop_now;
    assign status.do_shift  = (action_reg == ACT_INSERT) && !hit_now && !full;
    assign status.shift_end = (ptr_reg == pos_reg);

    // pointer and read pipeline
    always_comb
    begin
        ptr_next      = ptr_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        if (cmd.load)
        begin
            ptr_next = '0;
        end
        else if (cmd.scan)
        begin
            if (stop_now)
            begin
                ptr_next = count_reg;
            end
            else if (scan_issue)
            begin
                ptr_next      = ptr_reg + 1'b1;
                pend_next     = 1'b1;
                pend_idx_next = ptr_reg[AW-1:0];
            end
        end
        else if (shift_issue)
        begin
            ptr_next      = ptr_dec;
            pend_next     = 1'b1;
            pend_idx_next = ptr_reg[AW-1:0];
        end
    end

    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = ptr_reg[AW-1:0];
        ram_we    = 1'b0;
        ram_waddr = pend_idx_reg;
        ram_wdata = ram_rdata;
        if (cmd.scan)
        begin
            ram_re = scan_issue;
        end
        else if (cmd.shift)
        begin
            ram_re    = shift_issue;
            ram_raddr = ptr_dec[AW-1:0];
            ram_we    = pend_reg;
        end
        else if (cmd.place)
        begin
            ram_we    = 1'b1;
            ram_waddr = pos_reg[AW-1:0];
            ram_wdata = key_reg;
        end
        else if (cmd.mid)
        begin
            ram_re = 1'b1;
            if (count_reg > CW'(2))
            begin
                ram_raddr = AW'(count_reg >> 1);
            end
            else
            begin
                ram_raddr = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ptr_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            pend_reg <= pend_next;
            if (cmd.place)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        if (cmd.load)
        begin
            action_reg <= action;
            key_reg    <= value;
        end
        if (status.scan_stop)
        begin
            pos_reg     <= pos_now;
            outcome_reg <= outcome_now;
        end
    end

    sust_ram #(
        .WIDTH (SUST_DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign outcome      = outcome_reg;
    assign entry_count  = SUST_COUNT_W'(count_reg);
    assign middle_valid = (count_reg != '0);
    assign middle_value = middle_valid ? ram_rdata : '0;

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for sorted_unique_set_table_core.
// Drives insert and locate items through the start/busy handshake and checks
// every done strobe against a shadow copy of the ordered table. A short
// directed table covers the empty, single-entry and two-entry cases and the
// field extremes. Random traffic then fills the table slowly to capacity so
// that shifts at every position, duplicates and full rejects all appear.
// ----------------------------------------------------------------------------
module tb;
    import sust_pkg::*;

    localparam int TABLE_DEPTH  = SUST_CAPACITY;
    localparam int RANDOM_ITEMS = 1630;
    localparam int CALM_TAIL    = 150;
    localparam int SETTLE_CYCLES = 60;

    typedef struct packed {
        outcome_t                      outcome;
        logic [SUST_COUNT_W-1:0]       count;
        logic signed [SUST_DATA_W-1:0] middle;
        logic                          valid;
    } set_result_t;

    typedef struct packed {
        logic                          act;
        logic signed [SUST_DATA_W-1:0] val;
        logic                          typed;
        set_result_t                   fixed;
    } stim_row_t;

    localparam logic signed [SUST_DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [SUST_DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam int DIRECTED_ROWS = 22;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic                          action;
    logic signed [SUST_DATA_W-1:0] value;
    logic                          done;
    logic [2:0]                    outcome;
    logic [SUST_COUNT_W-1:0]       entry_count;
    logic signed [SUST_DATA_W-1:0] middle_value;
    logic                          middle_valid;

    logic signed [SUST_DATA_W-1:0] shadow_set [$];
    set_result_t                   awaited_results [$];
    int unsigned                   fail_count;

    // rows marked typed carry the result as read straight off the behaviour
    stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{ACT_LOCATE, 32'sd0,   1'b1, '{OUT_EMPTY,     6'd0, 32'sd0,  1'b0}},
        '{ACT_LOCATE, VAL_MIN,  1'b1, '{OUT_EMPTY,     6'd0, 32'sd0,  1'b0}},
        '{ACT_LOCATE, VAL_MAX,  1'b1, '{OUT_EMPTY,     6'd0, 32'sd0,  1'b0}},
        '{ACT_INSERT, 32'sd5,   1'b1, '{OUT_INSERTED,  6'd1, 32'sd5,  1'b1}},
        '{ACT_LOCATE, 32'sd5,   1'b1, '{OUT_FIRST,     6'd1, 32'sd5,  1'b1}},
        '{ACT_INSERT, 32'sd5,   1'b1, '{OUT_DUPLICATE, 6'd1, 32'sd5,  1'b1}},
        '{ACT_LOCATE, VAL_MAX,  1'b1, '{OUT_NOT_FOUND, 6'd1, 32'sd5,  1'b1}},
        '{ACT_LOCATE, VAL_MIN,  1'b1, '{OUT_NOT_FOUND, 6'd1, 32'sd5,  1'b1}},
        '{ACT_INSERT, -32'sd3,  1'b1, '{OUT_INSERTED,  6'd2, -32'sd3, 1'b1}},
        '{ACT_LOCATE, 32'sd5,   1'b1, '{OUT_LAST,      6'd2, -32'sd3, 1'b1}},
        '{ACT_LOCATE, -32'sd3,  1'b1, '{OUT_FIRST,     6'd2, -32'sd3, 1'b1}},
        '{ACT_INSERT, 32'sd100, 1'b0, '{OUT_INSERTED,  6'd0, 32'sd0,  1'b0}},
        '{ACT_LOCATE, 32'sd5,   1'b0, '{OUT_INSERTED,  6'd0, 32'sd0,  1'b0}},
        '{ACT_LOCATE, 32'sd100, 1'b0, '{OUT_INSERTED,  6'd0, 32'sd0,  1'b0}},
        '{ACT_LOCATE, 32'sd4,   1'b0, '{OUT_INSERTED,  6'd0, 32'sd0,  1'b0}},
        '{ACT_INSERT, 32'sd6,   1'b0, '{OUT_INSERTED,  6'd0, 32'sd0,  1'b0}},
        '{ACT_INSERT, -32'sd1,  1'b0, '{OUT_INSERTED,  6'd0, 32'sd0,  1'b0}},
        '{ACT_LOCATE, 32'sd6,   1'b0, '{OUT_INSERTED,  6'd0, 32'sd0,  1'b0}},
        '{ACT_INSERT, 32'sd5,   1'b0, '{OUT_INSERTED,  6'd0, 32'sd0,  1'b0}},
        '{ACT_LOCATE, -32'sd2,  1'b0, '{OUT_INSERTED,  6'd0, 32'sd0,  1'b0}},
        '{ACT_INSERT, 32'sh4000_0000, 1'b0, '{OUT_INSERTED, 6'd0, 32'sd0, 1'b0}},
        '{ACT_LOCATE, 32'sh4000_0000, 1'b0, '{OUT_INSERTED, 6'd0, 32'sd0, 1'b0}}
    };

    sorted_unique_set_table_core #(
        .CAPACITY(TABLE_DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .value        (value),
        .done         (done),
        .outcome      (outcome),
        .entry_count  (entry_count),
        .middle_value (middle_value),
        .middle_valid (middle_valid)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Applies one item to the shadow table and returns the result it should give.
    function automatic set_result_t predict_set_item(input logic act,
                                                     input logic signed [SUST_DATA_W-1:0] val);
        set_result_t res;
        int          n;
        int          pos;
        bit          hit;
        n   = shadow_set.size();
        pos = n;
        hit = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (shadow_set[i] == val)
            begin
                hit = 1'b1;
                pos = i;
                break;
            end
            if (val < shadow_set[i])
            begin
                pos = i;
                break;
            end
        end
        if (act == ACT_INSERT)
        begin
            if (hit)
                res.outcome = OUT_DUPLICATE;
            else if (n >= TABLE_DEPTH)
                res.outcome = OUT_FULL;
            else
            begin
                shadow_set.insert(pos, val);
                res.outcome = OUT_INSERTED;
            end
        end
        else if (n == 0)
            res.outcome = OUT_EMPTY;
        else if (!hit)
            res.outcome = OUT_NOT_FOUND;
        else if (pos == 0)
            res.outcome = OUT_FIRST;
        else if (pos == n - 1)
            res.outcome = OUT_LAST;
        else
            res.outcome = OUT_MIDDLE;
        n         = shadow_set.size();
        res.count = n[SUST_COUNT_W-1:0];
        if (n == 0)
        begin
            res.middle = '0;
            res.valid  = 1'b0;
        end
        else
        begin
            res.middle = shadow_set[(n <= 2) ? 0 : n / 2];
            res.valid  = 1'b1;
        end
        return res;
    endfunction

    task automatic send_item(input logic act, input logic signed [SUST_DATA_W-1:0] val,
                             input logic typed, input set_result_t fixed);
        set_result_t predicted;
        @(negedge clk);
        start  = 1'b1;
        action = act;
        value  = val;
        do @(posedge clk); while (busy);
        predicted = predict_set_item(act, val);
        awaited_results.push_back(typed ? fixed : predicted);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    task automatic drain_results();
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        set_result_t want;
        if (rst_n && done)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result with nothing expected: outcome %0d count %0d",
                         $time, outcome, entry_count);
                fail_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (outcome !== want.outcome)
                begin
                    $display("%0t: outcome expected %s, got %0d",
                             $time, want.outcome.name(), outcome);
                    fail_count++;
                end
                if (entry_count !== want.count)
                begin
                    $display("%0t: entry_count expected %0d, got %0d",
                             $time, want.count, entry_count);
                    fail_count++;
                end
                if (middle_value !== want.middle)
                begin
                    $display("%0t: middle_value expected %0d, got %0d",
                             $time, want.middle, middle_value);
                    fail_count++;
                end
                if (middle_valid !== want.valid)
                begin
                    $display("%0t: middle_valid expected %0d, got %0d",
                             $time, want.valid, middle_valid);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #(64'd6_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int unsigned                   pick;
        int unsigned                   fresh_pct;
        logic                          act;
        logic signed [SUST_DATA_W-1:0] val;
        set_result_t                   no_fixed;
        no_fixed   = '{OUT_INSERTED, '0, '0, 1'b0};
        fail_count = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        action     = ACT_INSERT;
        value      = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if ($urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 9));
            send_item(directed_rows[r].act, directed_rows[r].val,
                      directed_rows[r].typed, directed_rows[r].fixed);
        end
        pause_sender(1);
        drain_results();

        // fresh inserts are rare so the table fills slowly and reaches capacity late
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == RANDOM_ITEMS / 2)
            begin
                pause_sender(1);
                drain_results();
            end
            if (k < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 9));
            pick      = $urandom_range(0, 99);
            fresh_pct = (shadow_set.size() >= TABLE_DEPTH) ? 15 : 2;
            if (pick < fresh_pct)
            begin
                act = ACT_INSERT;
                val = $urandom;
            end
            else if (shadow_set.size() == 0)
            begin
                act = 1'($urandom_range(0, 1));
                val = $urandom;
            end
            else if (pick < 25)
            begin
                act = ACT_INSERT;
                val = shadow_set[$urandom_range(0, shadow_set.size() - 1)];
            end
            else if (pick < 60)
            begin
                act = ACT_LOCATE;
                val = shadow_set[$urandom_range(0, shadow_set.size() - 1)];
            end
            else if (pick < 80)
            begin
                act = ACT_LOCATE;
                val = shadow_set[$urandom_range(0, shadow_set.size() - 1)];
                val = $urandom_range(0, 1) ? val + 1 : val - 1;
            end
            else if (pick < 95)
            begin
                act = ACT_LOCATE;
                val = $urandom;
            end
            else
            begin
                act = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 5))
                    0:       val = VAL_MIN;
                    1:       val = VAL_MAX;
                    2:       val = 32'sd0;
                    3:       val = -32'sd1;
                    4:       val = 32'sd1;
                    default: val = VAL_MIN + 1;
                endcase
            end
            send_item(act, val, 1'b0, no_fixed);
        end
        pause_sender(1);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sorted_unique_set_table_core.f */
sv/sust_pkg.sv
sv/sust_ram.sv
sv/sust_ctrl.sv
sv/sust_datapath.sv
sv/sorted_unique_set_table_core.sv
dv/tb.sv
